FILE: rtl/lpht_pkg.sv
// shared definitions for the linear probing hash table
// field widths, operation and status codes, default table depth
// no dependencies
package lpht_pkg;

   localparam int unsigned KEY_W            = 64;
   localparam int unsigned VAL_W            = 64;
   localparam int unsigned STATUS_W         = 2;
   localparam int unsigned TABLE_DEPTH_DEF  = 1024;

   typedef logic [KEY_W-1:0]    key_type;
   typedef logic [VAL_W-1:0]    val_type;
   typedef logic [STATUS_W-1:0] status_type;

   // operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // result status codes
   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_NOT_FOUND = 2'd1;
   localparam status_type ST_FULL      = 2'd2;

endpackage

FILE: rtl/linear_probe_hash_table.sv
// a req beat runs through a probe walk of 1 to TABLE_DEPTH slots, then the output register raises rsp_valid;
//   for a depth that is not a power of two the 4-bit-per-cycle key mod depth comes first
// one operation at a time, one key memory read per cycle sets the probe rate;
//   the next req beat is taken once the result sits in the output register
// after reset a clearing pass writes empty into every key slot, with req_ready low
// a key of zero is answered without probing
module linear_probe_hash_table #(
   parameter int unsigned TABLE_DEPTH = lpht_pkg::TABLE_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_op,
   input  logic [lpht_pkg::KEY_W-1:0]   req_key,
   input  logic [lpht_pkg::VAL_W-1:0]   req_new_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [lpht_pkg::VAL_W-1:0]   rsp_found_value,
   output logic [lpht_pkg::STATUS_W-1:0] rsp_status
);

   import lpht_pkg::*;

   localparam int unsigned AW         = $clog2(TABLE_DEPTH);
   localparam bit          IS_POW2    = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
   localparam int unsigned HASH_BITS  = 4;
   localparam int unsigned HASH_STEPS = KEY_W / HASH_BITS;
   localparam int unsigned HCW        = $clog2(HASH_STEPS);

   localparam logic [AW:0]    DEPTH_W   = (AW+1)'(TABLE_DEPTH);
   localparam logic [AW-1:0]  LAST_SLOT = AW'(TABLE_DEPTH - 1);
   localparam logic [HCW-1:0] LAST_STEP = HCW'(HASH_STEPS - 1);

   // controller states
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_HASH  = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_CHECK = 3'd4;
   localparam logic [2:0] S_RESP  = 3'd5;

   logic [2:0]     state_ff,  state_in;
   logic           op_ff,     op_in;
   key_type        key_ff,    key_in;
   val_type        val_ff,    val_in;
   key_type        shift_ff,  shift_in;
   logic [AW-1:0]  rem_ff,    rem_in;
   logic [HCW-1:0] step_ff,   step_in;
   logic [AW-1:0]  slot_ff,   slot_in;
   logic [AW-1:0]  probe_ff,  probe_in;
   logic [AW-1:0]  clr_ff,    clr_in;
   val_type        res_value_ff,  res_value_in;
   status_type     res_status_ff, res_status_in;
   logic           rsp_valid_ff,  rsp_valid_in;
   val_type        rsp_value_ff,  rsp_value_in;
   status_type     rsp_status_ff, rsp_status_in;

   // memory ports
   logic          key_we;
   logic [AW-1:0] key_waddr;
   key_type       key_wdata;
   logic          val_we;
   logic [AW-1:0] rd_addr;
   key_type       key_rd;
   val_type       val_rd;

   logic [AW-1:0] rem_step;
   logic [AW-1:0] slot_next;
   logic          hit;
   logic          empty;
   logic          last;

   // key mod depth, four key bits per cycle, msb first: r = (2r + bit) mod depth
   always_comb begin
      logic [AW:0] wide;
      rem_step = rem_ff;
      for (int i = 0; i < HASH_BITS; i++) begin
         wide = {rem_step, shift_ff[KEY_W-1-i]};
         if (wide >= DEPTH_W) begin
            wide = wide - DEPTH_W;
         end
         rem_step = wide[AW-1:0];
      end
   end

   // probe step with wrap
   assign slot_next = (slot_ff == LAST_SLOT) ? '0 : slot_ff + AW'(1);

   // slot read back this cycle against the key in flight
   assign hit   = (key_rd == key_ff);
   assign empty = (key_rd == '0);
   assign last  = (probe_ff == LAST_SLOT);

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      shift_in      = shift_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      slot_in       = slot_ff;
      probe_in      = probe_ff;
      clr_in        = clr_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      key_we        = 1'b0;
      key_waddr     = slot_ff;
      key_wdata     = key_ff;
      val_we        = 1'b0;
      rd_addr       = slot_ff;

      unique case (state_ff)
         // sweep every key slot to empty
         S_CLEAR: begin
            key_we    = 1'b1;
            key_waddr = clr_ff;
            key_wdata = '0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == LAST_SLOT) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_op;
               key_in   = req_key;
               val_in   = req_new_value;
               shift_in = req_key;
               rem_in   = '0;
               step_in  = '0;
               slot_in  = req_key[AW-1:0];
               if (req_key == '0) begin
                  // empty marker key: no probing
                  res_value_in  = '0;
                  res_status_in = (req_op == OP_LOOKUP) ? ST_NOT_FOUND : ST_OK;
                  state_in      = S_RESP;
               end else if (IS_POW2) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_HASH;
               end
            end
         end

         S_HASH: begin
            shift_in = shift_ff << HASH_BITS;
            rem_in   = rem_step;
            step_in  = step_ff + HCW'(1);
            if (step_ff == LAST_STEP) begin
               slot_in  = rem_step;
               state_in = S_READ;
            end
         end

         // first probe read goes out
         S_READ: begin
            rd_addr  = slot_ff;
            probe_in = '0;
            state_in = S_CHECK;
         end

         // one probe per cycle, next read issued while checking this one
         S_CHECK: begin
            res_value_in = '0;
            if (op_ff == OP_INSERT) begin
               if (hit || empty) begin
                  key_we        = empty;
                  val_we        = 1'b1;
                  res_status_in = ST_OK;
                  state_in      = S_RESP;
               end else if (last) begin
                  res_status_in = ST_FULL;
                  state_in      = S_RESP;
               end else begin
                  rd_addr  = slot_next;
                  slot_in  = slot_next;
                  probe_in = probe_ff + AW'(1);
               end
            end else begin
               if (empty || (last && !hit)) begin
                  res_status_in = ST_NOT_FOUND;
                  state_in      = S_RESP;
               end else if (hit) begin
                  res_value_in  = val_rd;
                  res_status_in = ST_OK;
                  state_in      = S_RESP;
               end else begin
                  rd_addr  = slot_next;
                  slot_in  = slot_next;
                  probe_in = probe_ff + AW'(1);
               end
            end
         end

         // wait for the output register to free up
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      shift_ff      <= shift_in;
      rem_ff        <= rem_in;
      step_ff       <= step_in;
      slot_ff       <= slot_in;
      probe_ff      <= probe_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   // key store, cleared by the sweep after reset
   lpht_ram #(
      .WIDTH (KEY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_waddr),
      .wr_data (key_wdata),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   // value store, read alongside every key probe, its data used only where the key matched
   lpht_ram #(
      .WIDTH (VAL_W),
      .DEPTH (TABLE_DEPTH)
   ) u_val_ram (
      .clock   (clock),
      .wr_en   (val_we),
      .wr_addr (slot_ff),
      .wr_data (val_ff),
      .rd_addr (rd_addr),
      .rd_data (val_rd)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found_value = rsp_value_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

FILE: rtl/lpht_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module lpht_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/lpht_checker.sv
// port level checks for the linear probing hash table, bound to the top level
// depends on lpht_pkg and linear_probe_hash_table
module lpht_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [lpht_pkg::VAL_W-1:0]    rsp_found_value,
   input logic [lpht_pkg::STATUS_W-1:0] rsp_status
);

   import lpht_pkg::*;

   // clearing pass keeps the request side closed right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("req_ready high right after reset");

   // one operation in flight: an accepted beat closes the request side
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second beat taken while an operation is in flight");

   // only a successful lookup carries a value
   a_value_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> rsp_found_value == '0)
      else $error("nonzero value with a failing status");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_found_value) && $stable(rsp_status)))
      else $error("result beat changed while stalled");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);
